FILE: design/bsfr_pkg.sv
// shared types, codes and constants of the barcode scan frame receiver
package bsfr_pkg;

  localparam int MAX_CHARS_DEF = 32;

  // request codes
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_CANCEL = 2'd3;

  // read status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_READ  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_TRIGGER_MODE = 2'd0;
  localparam logic [1:0] REG_READ_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd2;

  localparam logic [1:0] MODE_SERIAL = 2'd0;

  localparam logic [15:0] READ_TIMEOUT_RST = 16'd2000;
  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd500;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7F;

  localparam logic [2:0] ACK_LEN = 3'd7;

  typedef logic [1:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_id;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] read_id;
    logic [1:0]  read_status;
    logic [5:0]  text_length;
    logic [15:0] text_word;
    logic        scanner_fault;
    logic        send_stop;
    logic        last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic in_open;
    logic load_head;
    logic rd_hi;
    logic rd_lo;
    logic load_word;
    logic idx_clr;
    logic idx_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;
    logic out_free;
    logic is_last;
  } sts_t;

  // scanner acknowledgement sequence 02 00 00 01 00 33 31
  function automatic logic [7:0] ack_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0: b = 8'h02;
      3'd3: b = 8'h01;
      3'd5: b = 8'h33;
      3'd6: b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/bsfr_datapath.sv
// read state, text store, config registers and output register
module bsfr_datapath #(
  parameter int MAX_CHARS = bsfr_pkg::MAX_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bsfr_pkg::in_t       in_data,
  input  logic                cfg_we,
  input  bsfr_pkg::cfg_idx_t  cfg_index,
  input  bsfr_pkg::cfg_data_t cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output bsfr_pkg::out_t      out_data,
  input  bsfr_pkg::cmd_t      cmd,
  output bsfr_pkg::sts_t      sts
);
  import bsfr_pkg::*;

  localparam int CntW   = $clog2(MAX_CHARS + 2);
  localparam int AddrW  = $clog2(MAX_CHARS);
  localparam int NWords = (MAX_CHARS + 1) / 2;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CHARS);
  localparam logic [CntW-1:0] LastHi = CntW'(2 * (NWords - 1));

  logic [1:0]      trigger_mode;
  logic [15:0]     read_timeout;
  logic [15:0]     ack_timeout;
  logic            reading;
  logic [15:0]     current_id;
  logic [2:0]      ack_matched;
  logic            ack_done;
  logic [CntW-1:0] char_count;
  logic [15:0]     age_ms;

  logic [7:0]      mem [MAX_CHARS];
  logic [7:0]      rd_byte;
  logic [7:0]      hi_byte;
  logic [CntW-1:0] idx;
  logic [1:0]      run_status;
  logic            run_fault;
  logic [CntW-1:0] run_len;

  logic            take, serial, ack_phase, ack_hit, is_eol, is_print;
  logic            byte_ev, tick_ev, ack_expired, read_expired;
  logic            fin_eol, fin_tick, finish, cnt_inc, store_wr;
  logic [15:0]     age_inc;
  logic [1:0]      fin_status;
  logic [CntW-1:0] fin_len;
  logic [CntW-1:0] idx_lo;
  logic [CntW-1:0] rd_addr;
  logic            rd_ok;
  logic [7:0]      lo_byte;
  logic [7:0]      b;

  assign b         = in_data.data_byte;
  assign take      = in_valid && cmd.in_open;
  assign serial    = (trigger_mode == MODE_SERIAL);
  assign ack_phase = serial && !ack_done;
  assign ack_hit   = ack_phase && (ack_matched < ACK_LEN) && (b == ack_byte(ack_matched));
  assign is_eol    = (b == CHAR_CR) || (b == CHAR_LF);
  assign is_print  = (b >= PRINT_LO) && (b < PRINT_HI);
  assign age_inc   = (age_ms != 16'hFFFF) ? age_ms + 16'd1 : age_ms;

  assign byte_ev      = take && reading && (in_data.req_type == REQ_BYTE);
  assign tick_ev      = take && reading && (in_data.req_type == REQ_TICK);
  assign ack_expired  = ack_phase && (age_inc > ack_timeout);
  assign read_expired = age_inc > read_timeout;

  // a byte that breaks the ack sequence falls through as data
  assign fin_eol  = byte_ev && !ack_hit && is_eol && (char_count != '0);
  assign fin_tick = tick_ev && (ack_expired || read_expired);
  assign finish   = fin_eol || fin_tick;
  assign cnt_inc  = byte_ev && !ack_hit && !is_eol && is_print && (char_count <= MaxCnt);
  assign store_wr = cnt_inc && (char_count < MaxCnt);

  always_comb begin
    if (fin_eol) begin
      fin_status = (char_count > MaxCnt) ? ST_TOO_LONG : ST_OK;
    end else begin
      fin_status = ST_NO_READ;
    end
    if (fin_status == ST_NO_READ) begin
      fin_len = '0;
    end else begin
      fin_len = (char_count > MaxCnt) ? MaxCnt : char_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_mode <= MODE_SERIAL;
      read_timeout <= READ_TIMEOUT_RST;
      ack_timeout  <= ACK_TIMEOUT_RST;
      reading      <= 1'b0;
      current_id   <= '0;
      ack_matched  <= '0;
      ack_done     <= 1'b0;
      char_count   <= '0;
      age_ms       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIGGER_MODE: trigger_mode <= cfg_data[1:0];
          REG_READ_TIMEOUT: read_timeout <= cfg_data;
          REG_ACK_TIMEOUT:  ack_timeout  <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        case (in_data.req_type)
          REQ_START: begin
            reading     <= 1'b1;
            current_id  <= in_data.request_id;
            ack_matched <= '0;
            ack_done    <= 1'b0;
            char_count  <= '0;
            age_ms      <= '0;
          end
          REQ_BYTE: begin
            if (reading) begin
              if (ack_hit) begin
                ack_matched <= ack_matched + 3'd1;
                if (ack_matched == ACK_LEN - 3'd1) begin
                  ack_done <= 1'b1;
                end
              end else begin
                if (ack_phase) begin
                  ack_done <= 1'b1;
                end
                if (cnt_inc) begin
                  char_count <= char_count + CntW'(1);
                end
              end
            end
          end
          REQ_TICK: begin
            if (reading) begin
              age_ms <= age_inc;
            end
          end
          REQ_CANCEL: reading <= 1'b0;
          default: ;
        endcase
        if (finish) begin
          reading <= 1'b0;
        end
      end
    end
  end

  // text store and result run fields
  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[char_count[AddrW-1:0]] <= b;
    end
    if (finish) begin
      run_status <= fin_status;
      run_fault  <= fin_tick && ack_expired;
      run_len    <= fin_len;
    end
  end

  assign idx_lo  = idx + CntW'(1);
  assign rd_addr = cmd.rd_lo ? idx_lo : idx;
  assign rd_ok   = (cmd.rd_hi || cmd.rd_lo) && (rd_addr < MaxCnt);
  assign lo_byte = (idx_lo < run_len) ? rd_byte : 8'h00;

  always_ff @(posedge clk) begin
    if (rd_ok) begin
      rd_byte <= mem[rd_addr[AddrW-1:0]];
    end
    if (cmd.rd_lo) begin
      hi_byte <= (idx < run_len) ? rd_byte : 8'h00;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_step) begin
      idx <= idx + CntW'(2);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_head || cmd.load_word) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head || cmd.load_word) begin
      out_data.item_kind     <= cmd.load_word;
      out_data.read_id       <= current_id;
      out_data.read_status   <= run_status;
      out_data.text_length   <= 6'(run_len);
      out_data.text_word     <= cmd.load_word ? {hi_byte, lo_byte} : 16'h0000;
      out_data.scanner_fault <= run_fault;
      out_data.send_stop     <= serial && (run_status != ST_OK);
      out_data.last          <= cmd.load_word && (idx == LastHi);
    end
  end

  assign sts.finish   = finish;
  assign sts.out_free = !out_valid || !out_stall;
  assign sts.is_last  = (idx == LastHi);

endmodule

FILE: design/bsfr_ctrl.sv
// controller: takes input words, then sequences the header and text words of a run
module bsfr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  bsfr_pkg::sts_t sts,
  output bsfr_pkg::cmd_t cmd,
  output logic           in_stall
);
  import bsfr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_RDH  = 5'b00100,
    S_RDL  = 5'b01000,
    S_WORD = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.in_open = 1'b1;
        if (sts.finish) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (sts.out_free) begin
          cmd.load_head = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next    = S_RDH;
        end
      end
      S_RDH: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_RDL;
      end
      S_RDL: begin
        // captures the high byte and fetches the low one
        cmd.rd_lo  = 1'b1;
        state_next = S_WORD;
      end
      S_WORD: begin
        if (sts.out_free) begin
          cmd.load_word = 1'b1;
          if (sts.is_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_step = 1'b1;
            state_next   = S_RDH;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = !cmd.in_open;

endmodule

FILE: design/barcode_scan_frame_receiver.sv
// top level of the barcode scan frame receiver
// Takes start, scanner byte, millisecond tick and cancel words, one word per cycle while no
// result is pending. A word that finishes a read (line end, or a timeout tick) emits a
// header plus (MAX_CHARS+1)/2 text words; the block then holds stall high until the last
// text word is loaded, which output stall can delay. The text store has a single read port:
// every text word takes two byte reads and one load of the output register. Text bytes at
// or beyond the reported length read as zero. Configuration is written through
// cfg_we/cfg_index/cfg_data only while idle: a rule for the user, not enforced by the block.
module barcode_scan_frame_receiver #(
  parameter int MAX_CHARS = bsfr_pkg::MAX_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsfr_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bsfr_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  bsfr_pkg::cfg_idx_t  cfg_index,
  input  bsfr_pkg::cfg_data_t cfg_data
);
  import bsfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bsfr_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a load never overwrites a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_head || cmd.load_word) |-> sts.out_free)
    else $error("output word overwritten while stalled");

  // a read can only finish on a word taken while the controller is idle
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    sts.finish |-> cmd.in_open)
    else $error("read finished outside idle");

  // a header load is followed by the first byte fetch
  a_head_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load_head |=> cmd.rd_hi)
    else $error("header not followed by text fetch");

  // no read reports no characters
  a_no_read_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_status == ST_NO_READ) |-> (out_data.text_length == 6'd0))
    else $error("no read with nonzero length");

endmodule
